/* rtl/cicmds_pkg.sv */
// ----------------------------------------------------------------------------
// cicmds_pkg
// shared codes, widths and constants of the cloud-in-cell mass deposit unit
// ----------------------------------------------------------------------------
package cicmds_pkg;

  localparam int KIND_W      = 2;
  localparam int POS_W       = 32;
  localparam int IDX_IN_W    = 15;
  localparam int DENS_W      = 48;
  localparam int TDATA_IN_W  = 112;  // 3 positions + cell index, padded to bytes
  localparam int TDATA_OUT_W = 48;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  // shared multiplier: signed operands, product
  localparam int OP_W   = 34;
  localparam int PROD_W = 68;

  // flat index width before it is fitted to the memory address
  localparam int FLAT_W = 18;

  localparam logic [16:0] Q16_ONE       = 17'h10000;
  localparam logic [63:0] HALF_CELL_Q32 = 64'h0000_0000_8000_0000;
  localparam logic [DENS_W-1:0] DENS_MAX = '1;

  typedef logic [KIND_W-1:0] kind_t;

  localparam kind_t KIND_DEPOSIT = 2'd0;
  localparam kind_t KIND_READ    = 2'd1;
  localparam kind_t KIND_SAMPLE  = 2'd2;
  localparam kind_t KIND_CLEAR   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_CELLS_PER_SIDE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_SCALE       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PART_MASS       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_CELL_VOLUME = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIODIC_MODE   = 3'd4;

endpackage

/* rtl/cicmds_ram.sv */
// ----------------------------------------------------------------------------
// cicmds_ram
// single-port ram, one write or read address per cycle, registered read
// ----------------------------------------------------------------------------
module cicmds_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* rtl/cic_mass_deposit_and_sample_unit.sv */
// ----------------------------------------------------------------------------
// cic_mass_deposit_and_sample_unit
// cloud-in-cell mass deposit, cell read, trilinear density sample and clear
// on a cubic grid of saturating fixed-point mass accumulators
// ----------------------------------------------------------------------------
//  channel   direction  handshake           payload
//  s_*       in         s_tvalid/s_tready   tuser: kind, tdata: pos_x/y/z, cell_index
//  m_*       out        m_tvalid/m_tready   tuser: saturated, tdata: density_value
//  cfg_*     in         cfg_valid/cfg_ready cfg_index, cfg_data
//
//  deposit: per-axis position split, modulo (periodic only), corner coordinates,
//  then weights and a mass add per corner inside the grid, a skip per other corner;
//  sample: the same with density weighting per corner, plus the hand-off; read: one cell
//  the rate is set by the single shared multiplier and the one ram port
//  reset starts a clearing pass over all GRID_SIDE**3 cells, s_tready stays low
//  a finished result sits in the output register while the next item is taken
//  cfg writes are always taken, cfg_ready is tied high
// ----------------------------------------------------------------------------
module cic_mass_deposit_and_sample_unit #(
  parameter int GRID_SIDE = 32,
  parameter int MASS_BITS = 48
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // kind
  input  logic [cicmds_pkg::KIND_W-1:0]        s_tuser,
  // pos_x, pos_y, pos_z, cell_index, pad
  input  logic [cicmds_pkg::TDATA_IN_W-1:0]    s_tdata,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // density_value
  output logic [cicmds_pkg::TDATA_OUT_W-1:0]   m_tdata,
  // saturated
  output logic                                 m_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [cicmds_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cicmds_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import cicmds_pkg::*;

  localparam int GRID_CELLS = GRID_SIDE * GRID_SIDE * GRID_SIDE;
  localparam int AW         = $clog2(GRID_CELLS);
  localparam int SUM_W      = ((MASS_BITS > 40) ? MASS_BITS : 40) + 1;
  localparam int NMAX       = (GRID_SIDE > 63) ? 63 : GRID_SIDE;

  localparam logic [4:0] S_CLR    = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_SPM    = 5'd2;
  localparam logic [4:0] S_SPS    = 5'd3;
  localparam logic [4:0] S_MOD    = 5'd4;
  localparam logic [4:0] S_AXIS   = 5'd5;
  localparam logic [4:0] S_IDX    = 5'd6;
  localparam logic [4:0] S_CORNER = 5'd7;
  localparam logic [4:0] S_WXY    = 5'd8;
  localparam logic [4:0] S_WT     = 5'd9;
  localparam logic [4:0] S_DADD   = 5'd10;
  localparam logic [4:0] S_RD     = 5'd11;
  localparam logic [4:0] S_RW     = 5'd12;
  localparam logic [4:0] S_DM1    = 5'd13;
  localparam logic [4:0] S_DM2    = 5'd14;
  localparam logic [4:0] S_DCOMB  = 5'd15;
  localparam logic [4:0] S_SM1    = 5'd16;
  localparam logic [4:0] S_SM2    = 5'd17;
  localparam logic [4:0] S_SCOMB  = 5'd18;
  localparam logic [4:0] S_SACC   = 5'd19;
  localparam logic [4:0] S_OUT    = 5'd20;

  // configuration
  logic [5:0]  cells_per_side;
  logic [31:0] pos_scale;
  logic [31:0] part_mass;
  logic [31:0] inv_cell_volume;
  logic        periodic_mode;

  // sequencer and item state
  logic [4:0]          state;
  kind_t               kind;
  logic [POS_W-1:0]    pos [3];
  logic [IDX_IN_W-1:0] cell_in;
  logic [1:0]          ax;
  logic [31:0]         flr [3];
  logic [15:0]         frac [3];
  logic [31:0]         mag [3];
  logic [5:0]          rem [3];
  logic [4:0]          bitcnt;
  logic [5:0]          mx [2];
  logic [5:0]          my [2];
  logic [5:0]          mz [2];
  logic [1:0]          vx, vy, vz;
  logic [FLAT_W-1:0]   xo [2];
  logic [FLAT_W-1:0]   yo [2];
  logic [2:0]          corner;
  logic [AW-1:0]       addr;
  logic [AW-1:0]       clr_cnt;
  logic [32:0]         wt;
  logic [65:0]         plo;
  logic [DENS_W-1:0]   dreg;
  logic [DENS_W-1:0]   result;
  logic                clip;
  logic [11:0]         nn;
  logic [PROD_W-1:0]   preg;

  // side in use, clamped to 1..NMAX (GRID_SIDE, at most 63)
  logic [5:0]  n;
  logic [17:0] n3;

  always_comb begin
    if (cells_per_side == 6'd0) begin
      n = 6'd1;
    end else if (32'(cells_per_side) > 32'(NMAX)) begin
      n = 6'(NMAX);
    end else begin
      n = cells_per_side;
    end
    n3 = 18'(nn * n);
  end

  // ram
  logic                 ram_we;
  logic [AW-1:0]        ram_addr;
  logic [MASS_BITS-1:0] ram_wdata;
  logic [MASS_BITS-1:0] ram_rdata;
  logic [63:0]          mass64;

  cicmds_ram #(
    .WIDTH (MASS_BITS),
    .DEPTH (GRID_CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign mass64 = 64'(ram_rdata);

  // corner weights and validity
  logic [16:0] wx_a, wy_b, wz_c;
  logic        corner_ok;
  logic [FLAT_W-1:0] flat_idx;

  always_comb begin
    wx_a = corner[2] ? {1'b0, frac[0]} : (Q16_ONE - {1'b0, frac[0]});
    wy_b = corner[1] ? {1'b0, frac[1]} : (Q16_ONE - {1'b0, frac[1]});
    wz_c = corner[0] ? {1'b0, frac[2]} : (Q16_ONE - {1'b0, frac[2]});
    corner_ok = vx[corner[2]] & vy[corner[1]] & vz[corner[0]];
    flat_idx = xo[corner[2]] + yo[corner[1]] + FLAT_W'(mz[corner[0]]);
  end

  // shared multiplier operand select
  logic signed [OP_W-1:0]   ma, mb;
  logic signed [PROD_W-1:0] prod;

  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      S_SPM: begin
        ma = {{2{pos[ax][31]}}, pos[ax]};
        mb = {2'b00, pos_scale};
      end
      S_CORNER: begin
        ma = {17'd0, wx_a};
        mb = {17'd0, wy_b};
      end
      S_WXY: begin
        ma = {17'd0, preg[32:16]};
        mb = {17'd0, wz_c};
      end
      S_WT: begin
        ma = {1'b0, preg[32:0]};
        mb = {2'b00, part_mass};
      end
      S_DM1: begin
        ma = {2'b00, mass64[31:0]};
        mb = {2'b00, inv_cell_volume};
      end
      S_DM2: begin
        ma = {2'b00, mass64[63:32]};
        mb = {2'b00, inv_cell_volume};
      end
      S_SM1: begin
        ma = {2'b00, dreg[31:0]};
        mb = {1'b0, wt};
      end
      S_SM2: begin
        ma = {18'd0, dreg[47:32]};
        mb = {1'b0, wt};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod = ma * mb;

  // position split: subtract half a cell for samples
  logic [63:0] split_v;
  assign split_v = preg[63:0] - ((kind == KIND_SAMPLE) ? HALF_CELL_Q32 : 64'd0);

  // combine of two partial products
  logic [97:0] pfull;
  assign pfull = {preg[65:0], 32'd0} + {32'd0, plo};

  // mass accumulate with saturation
  logic [SUM_W-1:0]     mass_sum;
  logic                 mass_clip;
  logic [MASS_BITS-1:0] mass_new;

  always_comb begin
    mass_sum  = SUM_W'(ram_rdata) + SUM_W'(preg[63:24]);
    mass_clip = |mass_sum[SUM_W-1:MASS_BITS];
    mass_new  = mass_clip ? '1 : mass_sum[MASS_BITS-1:0];
  end

  // sample sum with saturation
  logic [DENS_W:0] acc_sum;
  assign acc_sum = {1'b0, result} + {1'b0, dreg};

  // per-axis corner coordinates
  logic [5:0] m0 [3];
  logic [5:0] m1 [3];
  logic [1:0] vv [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic signed [32:0] c33;
      logic signed [32:0] n33;
      logic [5:0] r0;
      c33 = {flr[k][31], flr[k]};
      n33 = {27'd0, n};
      r0  = (flr[k][31] && (rem[k] != 6'd0)) ? (n - rem[k]) : rem[k];
      if (periodic_mode) begin
        m0[k] = r0;
        m1[k] = (r0 == (n - 6'd1)) ? 6'd0 : (r0 + 6'd1);
        vv[k] = 2'b11;
      end else begin
        m0[k] = flr[k][5:0];
        m1[k] = flr[k][5:0] + 6'd1;
        vv[k][0] = !flr[k][31] && (c33 < n33);
        vv[k][1] = (c33 >= -33'sd1) && (c33 < (n33 - 33'sd1));
      end
    end
  end

  // ram port
  always_comb begin
    ram_we    = (state == S_CLR) || (state == S_DADD);
    ram_addr  = (state == S_CLR) ? clr_cnt : addr;
    ram_wdata = (state == S_CLR) ? '0 : mass_new;
  end

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // next corner or end of the item
  logic [4:0] state_adv;
  assign state_adv = (corner != 3'd7) ? S_CORNER :
                     ((kind == KIND_DEPOSIT) ? S_IDLE : S_OUT);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cells_per_side  <= 6'd32;
      pos_scale       <= 32'd65536;
      part_mass       <= 32'd65536;
      inv_cell_volume <= 32'd65536;
      periodic_mode   <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CELLS_PER_SIDE:  cells_per_side  <= cfg_data[5:0];
        CFG_POS_SCALE:       pos_scale       <= cfg_data;
        CFG_PART_MASS:       part_mass       <= cfg_data;
        CFG_INV_CELL_VOLUME: inv_cell_volume <= cfg_data;
        CFG_PERIODIC_MODE:   periodic_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // datapath registers without reset
  always_ff @(posedge clk) begin
    preg <= prod;
    nn   <= 12'(n * n);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      clr_cnt  <= '0;
      clip     <= 1'b0;
      m_tvalid <= 1'b0;
      corner   <= 3'd0;
      ax       <= 2'd0;
      bitcnt   <= 5'd0;
    end else begin
      // the output stage reloads the register itself when it hands off
      if (m_tvalid && m_tready && (state != S_OUT)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == AW'(GRID_CELLS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            kind    <= s_tuser;
            pos[0]  <= s_tdata[31:0];
            pos[1]  <= s_tdata[63:32];
            pos[2]  <= s_tdata[95:64];
            cell_in <= s_tdata[110:96];
            result  <= '0;
            ax      <= 2'd0;
            corner  <= 3'd0;
            unique case (s_tuser)
              KIND_CLEAR: begin
                clip    <= 1'b0;
                clr_cnt <= '0;
                state   <= S_CLR;
              end
              KIND_READ: state <= S_RD;
              default:   state <= S_SPM;
            endcase
          end
        end
        S_SPM: state <= S_SPS;
        S_SPS: begin
          flr[ax]  <= split_v[63:32];
          frac[ax] <= split_v[31:16];
          mag[ax]  <= split_v[63] ? (32'd0 - split_v[63:32]) : split_v[63:32];
          rem[ax]  <= 6'd0;
          bitcnt   <= 5'd0;
          if (ax == 2'd2) begin
            state <= periodic_mode ? S_MOD : S_AXIS;
          end else begin
            ax    <= ax + 2'd1;
            state <= S_SPM;
          end
        end
        S_MOD: begin
          // one remainder bit per cycle on each axis
          for (int k = 0; k < 3; k++) begin
            logic [6:0] t;
            t = {rem[k], mag[k][31]};
            rem[k] <= (t >= {1'b0, n}) ? 6'(t - {1'b0, n}) : t[5:0];
            mag[k] <= {mag[k][30:0], 1'b0};
          end
          bitcnt <= bitcnt + 5'd1;
          if (bitcnt == 5'd31) begin
            state <= S_AXIS;
          end
        end
        S_AXIS: begin
          mx[0] <= m0[0]; mx[1] <= m1[0]; vx <= vv[0];
          my[0] <= m0[1]; my[1] <= m1[1]; vy <= vv[1];
          mz[0] <= m0[2]; mz[1] <= m1[2]; vz <= vv[2];
          state <= S_IDX;
        end
        S_IDX: begin
          for (int k = 0; k < 2; k++) begin
            xo[k] <= FLAT_W'(mx[k] * nn);
            yo[k] <= FLAT_W'(my[k] * n);
          end
          state <= S_CORNER;
        end
        S_CORNER: begin
          if (corner_ok) begin
            addr  <= AW'(flat_idx);
            state <= S_WXY;
          end else begin
            corner <= corner + 3'd1;
            state  <= state_adv;
          end
        end
        S_WXY: state <= S_WT;
        S_WT: begin
          wt    <= preg[32:0];
          state <= (kind == KIND_DEPOSIT) ? S_DADD : S_DM1;
        end
        S_DADD: begin
          if (mass_clip) begin
            clip <= 1'b1;
          end
          corner <= corner + 3'd1;
          state  <= state_adv;
        end
        S_RD: begin
          if (18'(cell_in) < n3) begin
            addr  <= AW'(cell_in);
            state <= S_RW;
          end else begin
            result <= '0;
            state  <= S_OUT;
          end
        end
        S_RW:  state <= S_DM1;
        S_DM1: state <= S_DM2;
        S_DM2: begin
          plo   <= preg[65:0];
          state <= S_DCOMB;
        end
        S_DCOMB: begin
          // cell density, product shifted down by 16
          if (|pfull[97:64]) begin
            clip <= 1'b1;
          end
          if (kind == KIND_READ) begin
            result <= (|pfull[97:64]) ? DENS_MAX : pfull[63:16];
            state  <= S_OUT;
          end else begin
            dreg  <= (|pfull[97:64]) ? DENS_MAX : pfull[63:16];
            state <= S_SM1;
          end
        end
        S_SM1: state <= S_SM2;
        S_SM2: begin
          plo   <= preg[65:0];
          state <= S_SCOMB;
        end
        S_SCOMB: begin
          // weighted density, product shifted down by 32
          if (|pfull[97:80]) begin
            clip <= 1'b1;
          end
          dreg  <= (|pfull[97:80]) ? DENS_MAX : pfull[79:32];
          state <= S_SACC;
        end
        S_SACC: begin
          if (acc_sum[DENS_W]) begin
            clip   <= 1'b1;
            result <= DENS_MAX;
          end else begin
            result <= acc_sum[DENS_W-1:0];
          end
          corner <= corner + 3'd1;
          state  <= state_adv;
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= result;
            m_tuser  <= clip;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/cicmds_checker.sv */
// ----------------------------------------------------------------------------
// cicmds_checker
// port-level checks of the cloud-in-cell unit, bound to the top level
// ----------------------------------------------------------------------------
module cicmds_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 s_tvalid,
  input logic                                 s_tready,
  input logic [cicmds_pkg::TDATA_OUT_W-1:0]   m_tdata,
  input logic                                 m_tvalid,
  input logic                                 m_tready
);

  import cicmds_pkg::*;

  // clearing pass follows reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("input ready right after reset");

  // one item at a time
  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input ready in the cycle after a beat");

  // a result only appears while an item is being worked on
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result raised while idle");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("output beat dropped or changed while stalled");

endmodule

bind cic_mass_deposit_and_sample_unit cicmds_checker u_cicmds_checker (.*);

/* sim/cic_mass_deposit_and_sample_unit_tb.sv */
// ----------------------------------------------------------------------------
// cic_mass_deposit_and_sample_unit_tb
// drives deposit, read, sample and clear beats through the stream port under
// random idling on both sides, predicts every density beat with a fixed-point
// model of the cloud-in-cell grid and compares it field by field
// ----------------------------------------------------------------------------
module cic_mass_deposit_and_sample_unit_tb;
  import cicmds_pkg::*;

  localparam int SIDE     = 32;
  localparam int CELLS    = SIDE * SIDE * SIDE;
  localparam longint LIMIT = 64'd40_000_000;
  localparam logic [47:0] MASS_TOP = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [47:0] dens;
    logic        sat;
  } dens_beat_t;

  typedef struct {
    kind_t       kind;
    logic [31:0] px, py, pz;
    logic [14:0] idx;
    logic        has_exp;   // typed-in expectation
    logic [47:0] exp_dens;
  } stim_row_t;

  logic clk = 0, rst = 1;
  logic [KIND_W-1:0] s_tuser = '0;
  logic [TDATA_IN_W-1:0] s_tdata = '0;
  logic s_tvalid = 0, s_tready;
  logic [TDATA_OUT_W-1:0] m_tdata;
  logic m_tuser, m_tvalid, m_tready = 0;
  logic cfg_valid = 0, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  cic_mass_deposit_and_sample_unit uut (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // predictor state: grid contents, sticky clip flag, register copies
  logic [47:0] mass_grid [CELLS];
  bit          clip_flag;
  logic [5:0]  side_reg;
  logic [31:0] icw_reg, pmass_reg, icv_reg;
  bit          wrap_reg;

  dens_beat_t density_q[$];
  int  errors = 0;
  bit  calm = 0;      // no idling stretch
  longint cyc = 0;

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // (a*b)>>s clipped at the 48-bit density maximum
  function automatic logic [47:0] scaled_prod(logic [63:0] a, logic [63:0] b, int s);
    logic [127:0] p;
    p = ({64'd0, a} * {64'd0, b}) >> s;
    if (p > MASS_TOP) begin
      clip_flag = 1;
      return MASS_TOP;
    end
    return p[47:0];
  endfunction

  function automatic logic [47:0] sum_clip(logic [47:0] a, logic [47:0] b);
    logic [48:0] t;
    t = a + b;
    if (t[48]) begin
      clip_flag = 1;
      return MASS_TOP;
    end
    return t[47:0];
  endfunction

  function automatic bit corner_axis(longint c, longint n, output longint o);
    if (wrap_reg) begin
      o = ((c % n) + n) % n;
      return 1;
    end
    if (c < 0 || c >= n) return 0;
    o = c;
    return 1;
  endfunction

  // returns 1 and fills the beat when the item yields a result
  function automatic bit predict_density(kind_t k, logic [31:0] p [3], logic [14:0] ci,
                                         output dens_beat_t r);
    longint n, flr [3], cx, cy, cz, fi;
    logic [63:0] wgt [3][2];
    logic [63:0] prod, wxy, wt;
    logic [47:0] acc;
    n = side_reg == 0 ? 1 : (side_reg > SIDE ? SIDE : side_reg);
    acc = '0;
    if (k == KIND_CLEAR) begin
      foreach (mass_grid[i]) mass_grid[i] = '0;
      clip_flag = 0;
      return 0;
    end
    if (k == KIND_READ) begin
      if (ci < n * n * n) acc = scaled_prod({16'd0, mass_grid[ci]}, {32'd0, icv_reg}, 16);
      r = '{acc, clip_flag};
      return 1;
    end
    for (int a = 0; a < 3; a++) begin
      prod = $signed({{32{p[a][31]}}, p[a]}) * $signed({32'd0, icw_reg});
      if (k == KIND_SAMPLE) prod = prod - HALF_CELL_Q32;
      flr[a] = $signed(prod) >>> 32;
      wgt[a][1] = {48'd0, prod[31:16]};
      wgt[a][0] = 64'd65536 - wgt[a][1];
    end
    for (int a = 0; a < 2; a++) begin
      if (!corner_axis(flr[0] + a, n, cx)) continue;
      for (int b = 0; b < 2; b++) begin
        if (!corner_axis(flr[1] + b, n, cy)) continue;
        wxy = (wgt[0][a] * wgt[1][b]) >> 16;
        for (int c = 0; c < 2; c++) begin
          if (!corner_axis(flr[2] + c, n, cz)) continue;
          wt = wxy * wgt[2][c];
          fi = (cx * n + cy) * n + cz;
          if (k == KIND_DEPOSIT)
            mass_grid[fi] = sum_clip(mass_grid[fi], 48'((wt * pmass_reg) >> 24));
          else
            acc = sum_clip(acc, scaled_prod(scaled_prod({16'd0, mass_grid[fi]},
                                                        {32'd0, icv_reg}, 16), wt, 32));
        end
      end
    end
    if (k == KIND_DEPOSIT) return 0;
    r = '{acc, clip_flag};
    return 1;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] i, logic [31:0] v);
    cfg_index <= i;
    cfg_data  <= v;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 0;
    case (i)
      CFG_CELLS_PER_SIDE:  side_reg  = v[5:0];
      CFG_POS_SCALE:       icw_reg   = v;
      CFG_PART_MASS:       pmass_reg = v;
      CFG_INV_CELL_VOLUME: icv_reg   = v;
      default:             wrap_reg  = v[0];
    endcase
    @(negedge clk);
  endtask

  // wait until every beat is back and the unit is idle again
  task automatic settle();
    while (density_q.size() != 0 || !s_tready) @(negedge clk);
  endtask

  task automatic send_item(stim_row_t row);
    logic [31:0] p [3];
    dens_beat_t r;
    while (!calm && $urandom_range(99) < 31) begin
      s_tvalid <= 0;
      @(negedge clk);
    end
    s_tuser  <= row.kind;
    s_tdata  <= {row.idx, row.pz, row.py, row.px};
    s_tvalid <= 1;
    do @(posedge clk); while (!s_tready);
    p = '{row.px, row.py, row.pz};
    if (predict_density(row.kind, p, row.idx, r)) begin
      if (row.has_exp && r.dens != row.exp_dens) begin
        $error("table entry dens exp %h model %h", row.exp_dens, r.dens);
        errors++;
      end
      density_q.push_back(r);
    end
    @(negedge clk);
  endtask

  // receiver with random stall
  always @(negedge clk)
    m_tready <= calm || ($urandom_range(99) >= 31);

  always @(posedge clk) begin
    dens_beat_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (density_q.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        e = density_q.pop_front();
        if (m_tdata != e.dens) begin
          $error("density_value exp %h got %h", e.dens, m_tdata);
          errors++;
        end
        if (m_tuser != e.sat) begin
          $error("saturated exp %0b got %0b", e.sat, m_tuser);
          errors++;
        end
      end
    end
  end

  function automatic stim_row_t mk(kind_t k, logic [31:0] x, logic [31:0] y,
                                   logic [31:0] z, logic [14:0] i,
                                   bit h = 0, logic [47:0] d = 0);
    stim_row_t s;
    s = '{k, x, y, z, i, h, d};
    return s;
  endfunction

  function automatic logic [31:0] rnd_pos(int lo_bias);
    case ($urandom_range(5))
      0: return $urandom;
      1: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
      default: return 32'($urandom_range(lo_bias * 65536 - 1));
    endcase
  endfunction

  stim_row_t dir_tab [$];
  stim_row_t rw;

  initial begin
    side_reg = 32; icw_reg = 65536; pmass_reg = 65536; icv_reg = 65536; wrap_reg = 1;
    foreach (mass_grid[i]) mass_grid[i] = '0;
    clip_flag = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed part: fresh grid reads, position extremes, half-cell shift,
    // a read of the last cell and clear
    dir_tab.push_back(mk(KIND_READ, 0, 0, 0, 15'd0, 1, 48'd0));
    dir_tab.push_back(mk(KIND_READ, 0, 0, 0, 15'h7FFF, 1, 48'd0));
    dir_tab.push_back(mk(KIND_DEPOSIT, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 0));
    dir_tab.push_back(mk(KIND_READ, 0, 0, 0, 15'(1*1024 + 2*32 + 3), 1, 48'h1_000000));
    dir_tab.push_back(mk(KIND_DEPOSIT, 32'h0001_8000, 32'h0001_8000, 32'h0001_8000, 0));
    dir_tab.push_back(mk(KIND_SAMPLE, 32'h0001_8000, 32'h0002_8000, 32'h0003_8000, 0));
    dir_tab.push_back(mk(KIND_SAMPLE, 32'h0002_0000, 32'h0002_0000, 32'h0002_0000, 0));
    dir_tab.push_back(mk(KIND_DEPOSIT, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 0));
    dir_tab.push_back(mk(KIND_DEPOSIT, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 0));
    dir_tab.push_back(mk(KIND_SAMPLE, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0));
    dir_tab.push_back(mk(KIND_READ, 0, 0, 0, 15'd32767, 0));
    dir_tab.push_back(mk(KIND_CLEAR, 0, 0, 0, 0));
    dir_tab.push_back(mk(KIND_READ, 0, 0, 0, 15'(1*1024 + 2*32 + 3), 1, 48'd0));
    foreach (dir_tab[i]) send_item(dir_tab[i]);
    s_tvalid <= 0;

    // sender pauses until every beat has come back
    settle();

    // phases over register settings, extremes included
    for (int ph = 0; ph < 8; ph++) begin
      int nitems;
      settle();
      case (ph)
        0: ;
        1: begin
          write_reg(CFG_CELLS_PER_SIDE, 4); write_reg(CFG_PERIODIC_MODE, 0);
        end
        2: begin
          write_reg(CFG_CELLS_PER_SIDE, 1); write_reg(CFG_PERIODIC_MODE, 1);
          write_reg(CFG_PART_MASS, 32'hFFFF_FFFF);
        end
        3: begin
          write_reg(CFG_CELLS_PER_SIDE, 0); write_reg(CFG_INV_CELL_VOLUME, 32'hFFFF_FFFF);
          write_reg(CFG_POS_SCALE, 32'hFFFF_FFFF);
        end
        4: begin
          write_reg(CFG_CELLS_PER_SIDE, 63); write_reg(CFG_POS_SCALE, 0);
          write_reg(CFG_INV_CELL_VOLUME, 0); write_reg(CFG_PART_MASS, 0);
        end
        5: begin
          write_reg(CFG_CELLS_PER_SIDE, 8); write_reg(CFG_POS_SCALE, 8 * 65536);
          write_reg(CFG_PART_MASS, $urandom); write_reg(CFG_INV_CELL_VOLUME, $urandom);
          write_reg(CFG_PERIODIC_MODE, 0);
        end
        6: begin
          write_reg(CFG_CELLS_PER_SIDE, 5); write_reg(CFG_POS_SCALE, $urandom);
          write_reg(CFG_PERIODIC_MODE, 1);
        end
        default: begin
          write_reg(CFG_CELLS_PER_SIDE, 32); write_reg(CFG_POS_SCALE, 65536);
          write_reg(CFG_PART_MASS, 65536 * 3); write_reg(CFG_INV_CELL_VOLUME, 65536);
        end
      endcase
      calm = (ph == 3);
      nitems = 250;
      for (int j = 0; j < nitems; j++) begin
        int roll;
        kind_t k;
        roll = $urandom_range(99);
        k = roll < 50 ? KIND_DEPOSIT : roll < 72 ? KIND_READ : roll < 98 ? KIND_SAMPLE
                                                                         : KIND_CLEAR;
        rw = mk(k, rnd_pos(side_reg == 0 ? 1 : side_reg), rnd_pos(side_reg == 0 ? 1 : side_reg),
                rnd_pos(side_reg == 0 ? 1 : side_reg),
                $urandom_range(9) == 0 ? 15'($urandom) : 15'($urandom_range(511)));
        send_item(rw);
      end
      s_tvalid <= 0;
      calm = 0;
    end

    // drain, then a short tail to catch stray beats
    settle();
    repeat (100) @(negedge clk);
    if (errors == 0 && density_q.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end
endmodule
